### rtl/actcs_pkg.sv
`timescale 1ns / 1ps

package actcs_pkg;

  localparam int CAPACITY_DEF    = 256;
  localparam int VALUE_WIDTH_DEF = 32;

  // Port field widths
  localparam int KEY_W   = 32;
  localparam int POS_W   = 9;
  localparam int PAR_W   = 8;
  localparam int VAL_W   = 32;
  localparam int LVL_W   = 4;
  localparam int COUNT_W = 9;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_CLEAR  = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } stat_t;

  typedef struct packed {
    stat_t              status;
    logic [POS_W-1:0]   position;
    logic [PAR_W-1:0]   parent_position;
    logic               left_valid;
    logic [VAL_W-1:0]   left_value;
    logic               right_valid;
    logic [VAL_W-1:0]   right_value;
    logic               sibling_valid;
    logic [VAL_W-1:0]   sibling_value;
    logic [LVL_W-1:0]   depth;
    logic [LVL_W-1:0]   height;
    logic [COUNT_W-1:0] node_count;
  } result_t;

endpackage

### rtl/actcs_mem.sv
`timescale 1ns / 1ps

module actcs_mem #(
  parameter int DEPTH = actcs_pkg::CAPACITY_DEF,
  parameter int AW    = 8,
  parameter int DW    = actcs_pkg::VALUE_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/actcs_ctrl.sv
`timescale 1ns / 1ps

module actcs_ctrl #(
  parameter int CAPACITY    = actcs_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = actcs_pkg::VALUE_WIDTH_DEF,
  parameter int AW          = 8,
  parameter int CNT_W       = 9
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_action,
  input  logic [actcs_pkg::KEY_W-1:0]    in_key,
  output logic                           mem_we,
  output logic [AW-1:0]                  mem_waddr,
  output logic [VALUE_WIDTH-1:0]         mem_wdata,
  output logic [AW-1:0]                  mem_raddr,
  input  logic [VALUE_WIDTH-1:0]         mem_rdata,
  output logic                           res_valid,
  input  logic                           res_ready,
  output actcs_pkg::result_t             res
);

  localparam int SW = CNT_W + 1;
  localparam int DW = $clog2(SW + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SEARCH, S_DEL_RD, S_DEL_WR, S_Q_LEFT, S_Q_RIGHT,
    S_Q_SIB, S_Q_LAST, S_CALC, S_DONE
  } state_t;

  state_t                 state_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   started_r;
  actcs_pkg::act_t        act_r;
  actcs_pkg::act_t        in_act;
  logic [VALUE_WIDTH-1:0] key_r;
  logic [SW-1:0]          rd_slot_r;
  logic                   cmp_vld_r;
  logic [SW-1:0]          cmp_slot_r;
  logic [SW-1:0]          pos_r;
  logic [SW-1:0]          par_r;
  actcs_pkg::stat_t       status_r;
  logic                   lv_r, rv_r, sv_r;
  logic [VALUE_WIDTH-1:0] lval_r, rval_r, sval_r;
  logic [SW-1:0]          dj_r, hj_r;
  logic [DW-1:0]          dep_r, hgt_r;

  logic [SW-1:0] cnt_ext, left_slot, right_slot;
  logic          hit;

  assign in_act     = actcs_pkg::act_t'(in_action);
  assign cnt_ext    = SW'(cnt_r);
  assign left_slot  = pos_r << 1;
  assign right_slot = left_slot + SW'(1);
  assign hit        = cmp_vld_r && (mem_rdata == key_r);
  assign in_ready   = (state_r == S_IDLE);
  assign res_valid  = (state_r == S_DONE);

  // Memory port steering: slot s lives at index s-1
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(cnt_r);
    mem_wdata = VALUE_WIDTH'(in_key);
    mem_raddr = AW'(rd_slot_r - SW'(1));
    case (state_r)
      S_IDLE: begin
        mem_we = in_valid && (in_act == actcs_pkg::ACT_INSERT) &&
                 (cnt_ext < SW'(CAPACITY));
      end
      S_DEL_RD: mem_raddr = AW'(cnt_ext - SW'(1));
      S_DEL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(pos_r - SW'(1));
        mem_wdata = mem_rdata;
      end
      S_Q_LEFT:  mem_raddr = AW'(left_slot - SW'(1));
      S_Q_RIGHT: mem_raddr = AW'(left_slot);
      S_Q_SIB:   mem_raddr = pos_r[0] ? AW'(pos_r - SW'(2)) : AW'(pos_r);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      started_r <= 1'b0;
      cmp_vld_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            act_r     <= in_act;
            key_r     <= VALUE_WIDTH'(in_key);
            status_r  <= actcs_pkg::ST_OK;
            pos_r     <= '0;
            par_r     <= '0;
            lv_r      <= 1'b0;
            rv_r      <= 1'b0;
            sv_r      <= 1'b0;
            lval_r    <= '0;
            rval_r    <= '0;
            sval_r    <= '0;
            dep_r     <= '0;
            hgt_r     <= '0;
            rd_slot_r <= SW'(1);
            cmp_vld_r <= 1'b0;
            state_r   <= S_DONE;
            case (in_act)
              actcs_pkg::ACT_INSERT: begin
                if (cnt_ext >= SW'(CAPACITY)) begin
                  status_r <= actcs_pkg::ST_FULL;
                end else begin
                  cnt_r     <= cnt_r + CNT_W'(1);
                  started_r <= 1'b1;
                end
              end
              actcs_pkg::ACT_DELETE: begin
                if (!started_r) begin
                  status_r <= actcs_pkg::ST_EMPTY;
                end else if (cnt_r == '0) begin
                  status_r <= actcs_pkg::ST_NOTFOUND;
                end else begin
                  state_r <= S_SEARCH;
                end
              end
              actcs_pkg::ACT_QUERY: begin
                if (cnt_r == '0) begin
                  status_r <= actcs_pkg::ST_NOTFOUND;
                end else begin
                  state_r <= S_SEARCH;
                end
              end
              actcs_pkg::ACT_CLEAR: begin
                cnt_r     <= '0;
                started_r <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        // Issue one slot read per cycle, compare the previous slot's data
        S_SEARCH: begin
          if (hit) begin
            pos_r     <= cmp_slot_r;
            cmp_vld_r <= 1'b0;
            state_r   <= (act_r == actcs_pkg::ACT_DELETE) ? S_DEL_RD : S_Q_LEFT;
          end else if (cmp_vld_r && (cmp_slot_r == cnt_ext)) begin
            cmp_vld_r <= 1'b0;
            status_r  <= actcs_pkg::ST_NOTFOUND;
            state_r   <= S_DONE;
          end else begin
            cmp_vld_r  <= (rd_slot_r <= cnt_ext);
            cmp_slot_r <= rd_slot_r;
            if (rd_slot_r <= cnt_ext) begin
              rd_slot_r <= rd_slot_r + SW'(1);
            end
          end
        end
        S_DEL_RD: state_r <= S_DEL_WR;
        // Move the last entry into the emptied slot
        S_DEL_WR: begin
          cnt_r   <= cnt_r - CNT_W'(1);
          state_r <= S_DONE;
        end
        S_Q_LEFT: begin
          par_r   <= pos_r >> 1;
          state_r <= S_Q_RIGHT;
        end
        S_Q_RIGHT: begin
          lv_r    <= (left_slot <= cnt_ext);
          lval_r  <= (left_slot <= cnt_ext) ? mem_rdata : '0;
          state_r <= S_Q_SIB;
        end
        S_Q_SIB: begin
          rv_r    <= (right_slot <= cnt_ext);
          rval_r  <= (right_slot <= cnt_ext) ? mem_rdata : '0;
          state_r <= S_Q_LAST;
        end
        S_Q_LAST: begin
          if ((pos_r > SW'(1)) && (pos_r[0] || ((pos_r + SW'(1)) <= cnt_ext))) begin
            sv_r   <= 1'b1;
            sval_r <= mem_rdata;
          end
          dj_r    <= pos_r >> 1;
          hj_r    <= left_slot;
          state_r <= S_CALC;
        end
        // Depth: halve to zero; height: double while within the count
        S_CALC: begin
          if (dj_r != '0) begin
            dj_r  <= dj_r >> 1;
            dep_r <= dep_r + DW'(1);
          end
          if (hj_r <= cnt_ext) begin
            hj_r  <= hj_r << 1;
            hgt_r <= hgt_r + DW'(1);
          end
          if ((dj_r == '0) && (hj_r > cnt_ext)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    res.status          = status_r;
    res.position        = actcs_pkg::POS_W'(pos_r);
    res.parent_position = actcs_pkg::PAR_W'(par_r);
    res.left_valid      = lv_r;
    res.left_value      = actcs_pkg::VAL_W'(lval_r);
    res.right_valid     = rv_r;
    res.right_value     = actcs_pkg::VAL_W'(rval_r);
    res.sibling_valid   = sv_r;
    res.sibling_value   = actcs_pkg::VAL_W'(sval_r);
    res.depth           = actcs_pkg::LVL_W'(dep_r);
    res.height          = actcs_pkg::LVL_W'(hgt_r);
    res.node_count      = actcs_pkg::COUNT_W'(cnt_r);
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_ext <= SW'(CAPACITY))
    else $error("node count above capacity");

  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_IDLE || state_r == S_DEL_WR))
    else $error("slot write outside insert or delete refill");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_act == actcs_pkg::ACT_CLEAR) |=>
      (cnt_r == '0 && !started_r))
    else $error("clear did not empty the tree");

  a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEL_WR) |=> (cnt_r == $past(cnt_r) - CNT_W'(1)))
    else $error("delete did not drop the count by one");
`endif

endmodule

### rtl/array_complete_tree_store.sv
`timescale 1ns / 1ps

// Complete binary tree kept in a slot memory with 1-based heap numbering.
// Each input transaction (tuser = action, tdata = key) yields exactly one
// result transaction. Delete and query scan slots 1..count through the
// memory's single read port, one slot per cycle. A delete then refills
// the slot with the last entry; a query reads both children and the
// sibling, then works out depth and height. One item is in work at a
// time; a finished result sits in the output register so the next
// transaction can be taken while the result waits for out_tready.
// The slot memory needs no clearing pass: only values in slots up to the
// live count are ever used; reads past it are masked off.
module array_complete_tree_store #(
  parameter int CAPACITY    = actcs_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = actcs_pkg::VALUE_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [31:0] key_value
  input  logic [1:0]   in_tuser,   // [1:0] action
  output logic         out_tvalid,
  input  logic         out_tready,
  // [8:0] position, [16:9] parent_position, [17] left_valid,
  // [49:18] left_value, [50] right_valid, [82:51] right_value,
  // [83] sibling_valid, [115:84] sibling_value, [119:116] depth,
  // [123:120] height, [132:124] node_count, [135:133] zero
  output logic [135:0] out_tdata,
  output logic [1:0]   out_tuser   // [1:0] status
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr, mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_wdata, mem_rdata;
  logic                   res_valid, res_ready;
  actcs_pkg::result_t     res;
  actcs_pkg::result_t     out_res_r;
  logic                   out_valid_r;

  actcs_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (VALUE_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  actcs_ctrl #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH),
    .AW          (AW),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (in_tuser),
    .in_key    (in_tdata),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: load when empty or draining this cycle
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
      out_res_r   <= res;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {3'b000,
                       out_res_r.node_count,
                       out_res_r.height,
                       out_res_r.depth,
                       out_res_r.sibling_value,
                       out_res_r.sibling_valid,
                       out_res_r.right_value,
                       out_res_r.right_valid,
                       out_res_r.left_value,
                       out_res_r.left_valid,
                       out_res_r.parent_position,
                       out_res_r.position};

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int CAPACITY     = actcs_pkg::CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1250;
  localparam int PHASE_ITEMS  = 150;        // transactions per idling phase
  localparam int HOLD_CYCLES  = 500;        // length of one long receiver hold-off
  localparam int DRAIN_CYCLES = 400;        // above the worst search latency
  localparam int LIMIT_CYCLES = 2_000_000;

  // Idling phases, cycled through as transactions are accepted.
  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct {
    actcs_pkg::act_t op;
    logic [31:0]     key;
  } tree_op_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [31:0]  in_tdata = '0;
  logic [1:0]   in_tuser = actcs_pkg::ACT_INSERT;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [135:0] out_tdata;
  logic [1:0]   out_tuser;

  array_complete_tree_store dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Stimulus not yet offered, and results predicted but not yet seen.
  tree_op_t           pending_ops[$];
  actcs_pkg::result_t expected_results[$];

  // Shadow copy of the tree, advanced once per accepted transaction.
  logic [31:0] shadow_slots [1:CAPACITY];
  int          shadow_count   = 0;
  bit          shadow_started = 1'b0;

  int         cycles = 0;
  int         items_in = 0;
  int         results_seen = 0;
  int         mismatches = 0;
  int         max_nodes = 0;
  int         status_hits [4] = '{0, 0, 0, 0};
  int         holdoff_left = 0;
  int         holdoffs_done = 0;
  idle_mode_t idle_phase;

  assign idle_phase = idle_mode_t'((items_in / PHASE_ITEMS) % 4);

  always @(posedge clk) cycles <= cycles + 1;

  function automatic bit roll(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // Lowest occupied slot holding the key, 0 when none does.
  function automatic int lowest_slot(logic [31:0] key);
    for (int i = 1; i <= shadow_count; i++) begin
      if (shadow_slots[i] == key) return i;
    end
    return 0;
  endfunction

  // Apply one transaction to the shadow tree and build the result it yields.
  function automatic actcs_pkg::result_t tree_apply(actcs_pkg::act_t op,
                                                    logic [31:0] key);
    actcs_pkg::result_t r;
    int                 n;
    int                 p;
    int                 j;
    int                 k;
    r = '0;
    n = shadow_count;
    case (op)
      actcs_pkg::ACT_INSERT: begin
        if (n >= CAPACITY) begin
          r.status = actcs_pkg::ST_FULL;
        end else begin
          shadow_started = 1'b1;
          shadow_count = n + 1;
          shadow_slots[n + 1] = key;
        end
      end
      actcs_pkg::ACT_DELETE: begin
        if (!shadow_started) begin
          r.status = actcs_pkg::ST_EMPTY;
        end else begin
          p = lowest_slot(key);
          if (p == 0) begin
            r.status = actcs_pkg::ST_NOTFOUND;
          end else begin
            // Refill the hole with the last entry, then shrink.
            shadow_slots[p] = shadow_slots[n];
            shadow_count = n - 1;
            r.position = actcs_pkg::POS_W'(p);
          end
        end
      end
      actcs_pkg::ACT_QUERY: begin
        p = lowest_slot(key);
        if (p == 0) begin
          r.status = actcs_pkg::ST_NOTFOUND;
        end else begin
          r.position = actcs_pkg::POS_W'(p);
          r.parent_position = actcs_pkg::PAR_W'(p / 2);
          if (2 * p <= n) begin
            r.left_valid = 1'b1;
            r.left_value = shadow_slots[2 * p];
          end
          if (2 * p + 1 <= n) begin
            r.right_valid = 1'b1;
            r.right_value = shadow_slots[2 * p + 1];
          end
          // Root has no sibling; an even slot may lack its right sibling.
          if (p > 1) begin
            if (p % 2 == 0) begin
              if (p + 1 <= n) begin
                r.sibling_valid = 1'b1;
                r.sibling_value = shadow_slots[p + 1];
              end
            end else begin
              r.sibling_valid = 1'b1;
              r.sibling_value = shadow_slots[p - 1];
            end
          end
          k = -1;
          for (j = p; j != 0; j = j / 2) k++;
          r.depth = actcs_pkg::LVL_W'(k);
          k = -1;
          for (j = p; j <= n; j = j * 2) k++;
          r.height = actcs_pkg::LVL_W'(k);
        end
      end
      default: begin
        shadow_count = 0;
        shadow_started = 1'b0;
      end
    endcase
    r.node_count = actcs_pkg::COUNT_W'(shadow_count);
    return r;
  endfunction

  task automatic queue_op(actcs_pkg::act_t op, logic [31:0] key);
    pending_ops.push_back('{op: op, key: key});
  endtask

  task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH result %0d field %s: expected %h, got %h",
                 results_seen, fname, want, got);
    end
  endtask

  // Driver: offer the head of pending_ops; hold tvalid and the payload until
  // the transaction is taken, and predict its result at the accepting edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= actcs_pkg::ACT_INSERT;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(tree_apply(actcs_pkg::act_t'(in_tuser), in_tdata));
        items_in <= items_in + 1;
      end
      if (!in_tvalid || in_tready) begin
        // Keep offering during a hold-off so the block backs up into its input.
        if (pending_ops.size() != 0 &&
            !(holdoff_left == 0 &&
              roll(idle_phase == IDLE_SEND ? 61 : idle_phase == IDLE_BOTH ? 12 : 0))) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_ops[0].key;
          in_tuser  <= pending_ops[0].op;
          pending_ops.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-offs, counted here and obeyed by the monitor.
  always @(posedge clk) begin
    if (!rst_n) begin
      holdoff_left <= 0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end else if (holdoffs_done < 2 && items_in >= (holdoffs_done == 0 ? 250 : 900)) begin
      holdoff_left  <= HOLD_CYCLES;
      holdoffs_done <= holdoffs_done + 1;
    end
  end

  // Monitor: take each result transaction and compare it with the oldest
  // expectation field by field; stall tready at random by phase.
  always @(posedge clk) begin : monitor
    actcs_pkg::result_t want;
    actcs_pkg::result_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status          = actcs_pkg::stat_t'(out_tuser);
        got.position        = out_tdata[8:0];
        got.parent_position = out_tdata[16:9];
        got.left_valid      = out_tdata[17];
        got.left_value      = out_tdata[49:18];
        got.right_valid     = out_tdata[50];
        got.right_value     = out_tdata[82:51];
        got.sibling_valid   = out_tdata[83];
        got.sibling_value   = out_tdata[115:84];
        got.depth           = out_tdata[119:116];
        got.height          = out_tdata[123:120];
        got.node_count      = out_tdata[132:124];
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("MISMATCH result %0d arrived with nothing expected", results_seen);
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("position", 32'(want.position), 32'(got.position));
          check_field("parent_position", 32'(want.parent_position),
                      32'(got.parent_position));
          check_field("left_valid", 32'(want.left_valid), 32'(got.left_valid));
          check_field("left_value", want.left_value, got.left_value);
          check_field("right_valid", 32'(want.right_valid), 32'(got.right_valid));
          check_field("right_value", want.right_value, got.right_value);
          check_field("sibling_valid", 32'(want.sibling_valid), 32'(got.sibling_valid));
          check_field("sibling_value", want.sibling_value, got.sibling_value);
          check_field("depth", 32'(want.depth), 32'(got.depth));
          check_field("height", 32'(want.height), 32'(got.height));
          check_field("node_count", 32'(want.node_count), 32'(got.node_count));
          check_field("tdata_pad", 32'd0, 32'(out_tdata[135:133]));
          if (int'(want.node_count) > max_nodes) max_nodes = int'(want.node_count);
          status_hits[want.status]++;
        end
        results_seen++;
      end
      out_tready <= holdoff_left == 0 &&
                    !roll(idle_phase == IDLE_RECV ? 61 : idle_phase == IDLE_BOTH ? 12 : 0);
    end
  end

  initial begin : stimulus
    logic [31:0] pool [16];
    logic [31:0] base;
    int          pool_n;
    int          len;
    int          pick;
    int          episode;

    // Directed: empty-tree delete and query, extreme keys, duplicates,
    // root, even and odd slots with and without a sibling, misses,
    // delete down to empty, clear and delete after clear.
    queue_op(actcs_pkg::ACT_DELETE, 32'd5);
    queue_op(actcs_pkg::ACT_QUERY,  32'd0);
    queue_op(actcs_pkg::ACT_INSERT, 32'h0000_0000);
    queue_op(actcs_pkg::ACT_INSERT, 32'hFFFF_FFFF);
    queue_op(actcs_pkg::ACT_INSERT, 32'h0000_0000);
    queue_op(actcs_pkg::ACT_INSERT, 32'h1234_5678);
    queue_op(actcs_pkg::ACT_INSERT, 32'hA5A5_5A5A);
    queue_op(actcs_pkg::ACT_QUERY,  32'h0000_0000);
    queue_op(actcs_pkg::ACT_QUERY,  32'hFFFF_FFFF);
    queue_op(actcs_pkg::ACT_QUERY,  32'hA5A5_5A5A);
    queue_op(actcs_pkg::ACT_QUERY,  32'h1234_5678);
    queue_op(actcs_pkg::ACT_QUERY,  32'h0000_0001);
    queue_op(actcs_pkg::ACT_DELETE, 32'h0000_0000);
    queue_op(actcs_pkg::ACT_QUERY,  32'h1234_5678);
    queue_op(actcs_pkg::ACT_DELETE, 32'hDEAD_BEEF);
    queue_op(actcs_pkg::ACT_DELETE, 32'hFFFF_FFFF);
    queue_op(actcs_pkg::ACT_DELETE, 32'hA5A5_5A5A);
    queue_op(actcs_pkg::ACT_DELETE, 32'h1234_5678);
    queue_op(actcs_pkg::ACT_DELETE, 32'h0000_0000);
    queue_op(actcs_pkg::ACT_DELETE, 32'h0000_0000);
    queue_op(actcs_pkg::ACT_INSERT, 32'd7);
    queue_op(actcs_pkg::ACT_CLEAR,  32'd7);
    queue_op(actcs_pkg::ACT_DELETE, 32'd7);
    queue_op(actcs_pkg::ACT_QUERY,  32'd7);
    queue_op(actcs_pkg::ACT_CLEAR,  32'hFFFF_FFFF);

    // Random: episodes of operations on a small key pool so that deletes
    // and queries hit, with a few full-range keys mixed in as noise.
    // One episode fills the store to capacity with distinct keys.
    episode = 0;
    while (pending_ops.size() < 25 + RANDOM_ITEMS) begin
      if (episode == 3) begin
        base = $urandom;
        queue_op(actcs_pkg::ACT_CLEAR, $urandom);
        for (int i = 0; i < CAPACITY; i++) queue_op(actcs_pkg::ACT_INSERT, base + i);
        for (int i = 0; i < 4; i++) queue_op(actcs_pkg::ACT_INSERT, $urandom);
        queue_op(actcs_pkg::ACT_QUERY, base + CAPACITY - 1);
        queue_op(actcs_pkg::ACT_QUERY, base);
        queue_op(actcs_pkg::ACT_QUERY, base + CAPACITY / 2 - 1);
        queue_op(actcs_pkg::ACT_QUERY, base + CAPACITY / 2);
        for (int i = 0; i < 30; i++)
          queue_op(actcs_pkg::ACT_QUERY, base + $urandom_range(CAPACITY - 1));
        for (int i = 0; i < 20; i++) begin
          queue_op(actcs_pkg::ACT_DELETE, base + $urandom_range(CAPACITY - 1));
          queue_op(actcs_pkg::ACT_QUERY, base + $urandom_range(CAPACITY - 1));
        end
        for (int i = 0; i < 10; i++) queue_op(actcs_pkg::ACT_INSERT, $urandom);
      end else begin
        pool_n = $urandom_range(16, 4);
        for (int i = 0; i < pool_n; i++) pool[i] = $urandom;
        if (roll(50)) queue_op(actcs_pkg::ACT_CLEAR, $urandom);
        len = $urandom_range(80, 20);
        for (int i = 0; i < len; i++) begin
          base = roll(85) ? pool[$urandom_range(pool_n - 1)] : $urandom;
          pick = $urandom_range(99);
          if (pick < 40)      queue_op(actcs_pkg::ACT_INSERT, base);
          else if (pick < 65) queue_op(actcs_pkg::ACT_DELETE, base);
          else if (pick < 95) queue_op(actcs_pkg::ACT_QUERY, base);
          else                queue_op(actcs_pkg::ACT_CLEAR, base);
        end
      end
      episode++;
    end

    // Hold reset, then release it for good.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every transaction to go in and every result to come back.
    while (!(pending_ops.size() == 0 && !in_tvalid && expected_results.size() == 0) &&
           cycles < LIMIT_CYCLES)
      @(posedge clk);

    if (cycles >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, expected_results.size());
      $display("CHECKS FAILED");
    end else begin
      // Let any stray result surface before judging.
      repeat (DRAIN_CYCLES) @(posedge clk);
      if (expected_results.size() != 0) begin
        mismatches++;
        $display("%0d expected results never arrived", expected_results.size());
      end
      $display("Summary: %0d transactions in, %0d results checked, largest tree %0d nodes",
               items_in, results_seen, max_nodes);
      $display("Summary: ok %0d, not found %0d, store full %0d, tree empty %0d; %0d mismatches",
               status_hits[actcs_pkg::ST_OK], status_hits[actcs_pkg::ST_NOTFOUND],
               status_hits[actcs_pkg::ST_FULL], status_hits[actcs_pkg::ST_EMPTY],
               mismatches);
      if (mismatches == 0) begin
        $display("ALL CHECKS PASSED");
      end else begin
        $display("CHECKS FAILED");
      end
    end
    $finish;
  end

endmodule

### array_complete_tree_store.f
rtl/actcs_pkg.sv
rtl/actcs_mem.sv
rtl/actcs_ctrl.sv
rtl/array_complete_tree_store.sv
verif/tb.sv
